// ===== sv/wsts_pkg.sv =====
// Shared constants and types for the weighted seven-tap smoother.
// Used by the scaling stage and by the top level; depends on nothing else.
`default_nettype none

package wsts_pkg;

    // Result sample format: signed, four fraction bits.
    localparam int OUT_W       = 20;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int OUT_MAX     = 524287;
    localparam int OUT_MIN     = -524288;

    // One input transfer causes at most four result transfers.
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W      = 2;
    localparam int COUNT_W     = 3;

    // Position counter: saturates once six samples of the stream are held.
    localparam logic [COUNT_W-1:0] COUNT_FULL = 3'd6;
    localparam logic [COUNT_W-1:0] EDGE_SPAN  = 3'd3;

    // Weights of the six history cells; the newest sample has weight one.
    localparam int CELL_COUNT = 6;
    localparam int CELL_WEIGHT [CELL_COUNT] = '{1, 2, 3, 3, 3, 2};

    // floor(s / 15) = (s * DIV15_MULT + DIV15_BIAS) >>> DIV15_SHIFT for any
    // 20-bit signed s. The bias folds in an offset that keeps the reciprocal
    // product exact for negative values.
    localparam int PROD_W      = 44;
    localparam int DIV15_SHIFT = 25;
    localparam int QUOT_W      = PROD_W - DIV15_SHIFT;
    localparam logic signed [PROD_W-1:0] DIV15_MULT = 44'sd2236963;
    localparam logic signed [PROD_W-1:0] DIV15_BIAS = 44'sd851968;

    // Results caused by one input sample, in output order.
    typedef struct packed {
        logic [COUNT_W-1:0]                  count;
        logic                                smoothed;
        logic [MAX_RESULTS-1:0][OUT_W-1:0]   value;
    } job_t;

    // Output of the scaling stage for the weighted sum.
    typedef struct packed {
        logic                       sat_hi;
        logic                       sat_lo;
        logic signed [OUT_W-1:0]    sum;
        logic signed [PROD_W-1:0]   prod;
    } scale_t;

endpackage

`default_nettype wire

// ===== sv/wsts_cell.sv =====
// One cell of the smoother chain: a history tap and a transposed partial sum.
// Stand-alone; instantiated six times by the top level.
`default_nettype none

module wsts_cell #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int SUM_WIDTH    = 20,
    parameter int WEIGHT       = 1
) (
    input  logic                           aclk,
    input  logic                           shift_en,
    input  logic signed [SAMPLE_WIDTH-1:0] x_in,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic signed [SUM_WIDTH-1:0]    psum_in,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic signed [SUM_WIDTH-1:0]    psum_out
);

    localparam logic signed [SUM_WIDTH-1:0] W = SUM_WIDTH'(WEIGHT);

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_next;
    logic signed [SUM_WIDTH-1:0]    psum_reg;
    logic signed [SUM_WIDTH-1:0]    psum_next;
    logic signed [SUM_WIDTH-1:0]    x_wide;

    // The tap takes its neighbor's sample; the partial sum adds this weight
    // times the new sample to the neighbor's partial sum.
    always_comb begin
        x_wide      = SUM_WIDTH'(x_in);
        sample_next = sample_in;
        psum_next   = psum_in + x_wide * W;
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            sample_reg <= sample_next;
            psum_reg   <= psum_next;
        end
    end

    assign sample_out = sample_reg;
    assign psum_out   = psum_reg;

endmodule

`default_nettype wire

// ===== sv/wsts_scale.sv =====
// Scaling stage: range check of the weighted sum and reciprocal product by 15.
// Depends on wsts_pkg.
`default_nettype none

module wsts_scale #(
    parameter int SUM_WIDTH = 21
) (
    input  logic                        aclk,
    input  logic                        load,
    input  logic signed [SUM_WIDTH-1:0] sum_in,
    output wsts_pkg::scale_t            scale_out
);

    import wsts_pkg::*;

    localparam logic signed [SUM_WIDTH-1:0] LIM_HI = SUM_WIDTH'(OUT_MAX);
    localparam logic signed [SUM_WIDTH-1:0] LIM_LO = SUM_WIDTH'(OUT_MIN);

    scale_t                    scale_reg;
    scale_t                    scale_next;
    logic signed [PROD_W-1:0]  sum_wide;

    // Sums outside 20 bits saturate anyway, since the gain 16/15 exceeds one.
    always_comb begin
        scale_next.sat_hi = (sum_in > LIM_HI);
        scale_next.sat_lo = (sum_in < LIM_LO);
        scale_next.sum    = sum_in[OUT_W-1:0];
        sum_wide          = PROD_W'(scale_next.sum);
        scale_next.prod   = sum_wide * DIV15_MULT + DIV15_BIAS;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            scale_reg <= scale_next;
        end
    end

    assign scale_out = scale_reg;

endmodule

`default_nettype wire

// ===== sv/weighted_seven_tap_smoother_unit.sv =====
// Top level of the weighted seven-tap smoother: cell chain, pipeline, output.
// Depends on wsts_pkg, wsts_cell and wsts_scale.
//
// Usage:
//   The slave stream carries one signed sample per transfer in s_axis_tdata,
//   with s_axis_tlast marking the final sample of a stream. The master stream
//   carries results: out_value in m_axis_tdata, is_smoothed in m_axis_tuser
//   and, in m_axis_tlast, a flag on the last result caused by one sample.
//   Inside a stream the result for a sample appears when the sample three
//   later arrives: the (1,2,3,3,3,2,1) weighted sum times 16/15, floored,
//   or the raw sample times 16 at the first three positions. The final
//   sample flushes up to four results and starts a new stream.
//   Results show on m_axis_tvalid from stage three. Throughput is one sample
//   per cycle while m_axis_tready is high: a stream yields as many results as
//   samples, and the output register hands out one per cycle. A final sample
//   releases up to four results at once; the three stages absorb the burst,
//   and s_axis_tready drops only when short streams follow closely.
//   Reset clears the position count and empties the three-stage pipeline.
//   When the receiver stalls, the three stages fill and s_axis_tready falls.
`default_nettype none

module weighted_seven_tap_smoother_unit #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // tdata: sample [SAMPLE_WIDTH-1:0], zero padding above.
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
    input  logic                                    s_axis_tlast,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: out_value [19:0], zero padding above.
    output logic [wsts_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // tuser: is_smoothed [0].
    output logic                                    m_axis_tuser,
    output logic                                    m_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready
);

    import wsts_pkg::*;

    localparam int SUM_W = SAMPLE_WIDTH + 4;
    localparam int EXT_W = (SUM_W > OUT_W + 1) ? SUM_W : OUT_W + 1;
    localparam logic signed [EXT_W-1:0] LIM_HI = EXT_W'(OUT_MAX);
    localparam logic signed [EXT_W-1:0] LIM_LO = EXT_W'(OUT_MIN);

    // Raw result: sample times 16, saturated to the output range.
    function automatic logic [OUT_W-1:0] raw_scale(input logic signed [SAMPLE_WIDTH-1:0] s);
        logic signed [EXT_W-1:0] e;
        logic [OUT_W-1:0]        r;
        e = EXT_W'(s);
        e = e <<< 4;
        if (e > LIM_HI) begin
            r = OUT_W'(OUT_MAX);
        end else if (e < LIM_LO) begin
            r = OUT_W'(OUT_MIN);
        end else begin
            r = e[OUT_W-1:0];
        end
        return r;
    endfunction

    logic                           s_accept;
    logic signed [SAMPLE_WIDTH-1:0] x;

    logic signed [SAMPLE_WIDTH-1:0] hist [CELL_COUNT];
    logic signed [SUM_W-1:0]        psum [CELL_COUNT];

    logic [COUNT_W-1:0]             count_reg;
    logic [COUNT_W-1:0]             count_next;

    job_t                           job_new;
    logic [COUNT_W-1:0]             slot_cnt;

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    job_t                           s1_job_reg;
    logic signed [EXT_W-1:0]        s1_sum_reg;
    logic signed [EXT_W-1:0]        s1_sum_next;

    logic                           s2_valid_reg;
    logic                           s2_valid_next;
    job_t                           s2_job_reg;
    scale_t                         s2_scale;

    logic                           s3_valid_reg;
    logic                           s3_valid_next;
    job_t                           s3_job_reg;
    job_t                           s3_job_next;
    logic [SLOT_W-1:0]              s3_ptr_reg;
    logic [SLOT_W-1:0]              s3_ptr_next;

    logic signed [QUOT_W-1:0]       quot;
    logic signed [OUT_W:0]          smooth_sum;
    logic [OUT_W-1:0]               smooth_val;

    logic                           out_xfer;
    logic                           out_last;
    logic                           s3_free;
    logic                           s2_free;
    logic                           s2_move;
    logic                           s1_free;
    logic                           s1_move;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign x        = s_axis_tdata[SAMPLE_WIDTH-1:0];

    // Chain of six cells; the newest sample enters at the last cell and the
    // partial sums run from the first cell toward the last.
    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
        logic signed [SAMPLE_WIDTH-1:0] tap_in;
        logic signed [SUM_W-1:0]        sum_in;

        if (k == CELL_COUNT - 1) begin : g_newest
            assign tap_in = x;
        end else begin : g_inner
            assign tap_in = hist[k+1];
        end

        if (k == 0) begin : g_first
            assign sum_in = '0;
        end else begin : g_chain
            assign sum_in = psum[k-1];
        end

        wsts_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .SUM_WIDTH    (SUM_W),
            .WEIGHT       (CELL_WEIGHT[k])
        ) u_cell (
            .aclk       (aclk),
            .shift_en   (s_accept),
            .x_in       (x),
            .sample_in  (tap_in),
            .psum_in    (sum_in),
            .sample_out (hist[k]),
            .psum_out   (psum[k])
        );
    end

    // Position count within the stream.
    always_comb begin
        if (s_axis_tlast) begin
            count_next = '0;
        end else if (count_reg < COUNT_FULL) begin
            count_next = count_reg + 3'd1;
        end else begin
            count_next = COUNT_FULL;
        end
    end

    // Results caused by this sample: the centered sample if one is due, then
    // on the final sample the held raw tail and the sample itself.
    always_comb begin
        job_new  = '0;
        slot_cnt = '0;
        if (count_reg >= COUNT_FULL) begin
            job_new.smoothed = 1'b1;
            slot_cnt         = 3'd1;
        end else if (count_reg >= EDGE_SPAN) begin
            job_new.value[0] = raw_scale(hist[3]);
            slot_cnt         = 3'd1;
        end
        if (s_axis_tlast) begin
            if (count_reg >= 3'd2) begin
                job_new.value[slot_cnt[SLOT_W-1:0]] = raw_scale(hist[4]);
                slot_cnt = slot_cnt + 3'd1;
            end
            if (count_reg >= 3'd1) begin
                job_new.value[slot_cnt[SLOT_W-1:0]] = raw_scale(hist[5]);
                slot_cnt = slot_cnt + 3'd1;
            end
            job_new.value[slot_cnt[SLOT_W-1:0]] = raw_scale(x);
            slot_cnt = slot_cnt + 3'd1;
        end
        job_new.count = slot_cnt;
    end

    // Pipeline flow: each stage loads when the one after it can take its job.
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign out_last = s3_valid_reg && (({1'b0, s3_ptr_reg} + 3'd1) == s3_job_reg.count);
    assign s3_free  = !s3_valid_reg || (out_xfer && out_last);
    assign s2_move  = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_axis_tready = s1_free;

    // Stage one: full weighted sum; jobs without results are dropped here.
    always_comb begin
        s1_sum_next   = EXT_W'(psum[CELL_COUNT-1]) + EXT_W'(x);
        s1_valid_next = s1_valid_reg;
        if (s1_free) begin
            s1_valid_next = s_accept && (job_new.count != '0);
        end
    end

    // Stage two: scaling by 16/15 in its own unit.
    always_comb begin
        s2_valid_next = s2_valid_reg;
        if (s2_free) begin
            s2_valid_next = s1_valid_reg;
        end
    end

    wsts_scale #(
        .SUM_WIDTH (EXT_W)
    ) u_scale (
        .aclk      (aclk),
        .load      (s1_move),
        .sum_in    (s1_sum_reg),
        .scale_out (s2_scale)
    );

    // Stage three: sum plus floor(sum / 15), saturated, then handed out one
    // result per transfer.
    always_comb begin
        quot       = s2_scale.prod[PROD_W-1:DIV15_SHIFT];
        smooth_sum = (OUT_W + 1)'(s2_scale.sum) + (OUT_W + 1)'(quot);
        if (s2_scale.sat_hi || (smooth_sum > (OUT_W + 1)'(OUT_MAX))) begin
            smooth_val = OUT_W'(OUT_MAX);
        end else if (s2_scale.sat_lo || (smooth_sum < (OUT_W + 1)'(OUT_MIN))) begin
            smooth_val = OUT_W'(OUT_MIN);
        end else begin
            smooth_val = smooth_sum[OUT_W-1:0];
        end

        s3_job_next = s2_job_reg;
        if (s2_job_reg.smoothed) begin
            s3_job_next.value[0] = smooth_val;
        end

        s3_valid_next = s3_valid_reg;
        s3_ptr_next   = s3_ptr_reg;
        if (s3_free) begin
            s3_valid_next = s2_valid_reg;
            s3_ptr_next   = '0;
        end else if (out_xfer) begin
            s3_ptr_next = s3_ptr_reg + 2'd1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s3_ptr_reg   <= '0;
        end else begin
            if (s_accept) begin
                count_reg <= count_next;
            end
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s3_ptr_reg   <= s3_ptr_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_job_reg <= job_new;
            s1_sum_reg <= s1_sum_next;
        end
        if (s1_move) begin
            s2_job_reg <= s1_job_reg;
        end
        if (s2_move) begin
            s3_job_reg <= s3_job_next;
        end
    end

    // Result channel.
    assign m_axis_tvalid = s3_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(s3_job_reg.value[s3_ptr_reg]);
    assign m_axis_tuser  = s3_job_reg.smoothed && (s3_ptr_reg == '0);
    assign m_axis_tlast  = out_last;

    // The output pointer always stays inside the job's result list.
    a_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> ({1'b0, s3_ptr_reg} < s3_job_reg.count))
        else $error("output pointer beyond the job's results");

    // The position count saturates at six.
    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_FULL)
        else $error("position count above six");

    // A final sample restarts the count and always leaves a job in stage one.
    a_last_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_axis_tlast) |=> ((count_reg == '0) && s1_valid_reg))
        else $error("final sample did not flush");

    // A smoothed result is alone, or followed by the three tail results.
    a_smooth_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_job_reg.smoothed)
            |-> ((s1_job_reg.count == 3'd1) || (s1_job_reg.count == 3'd4)))
        else $error("smoothed job with an impossible result count");

endmodule

`default_nettype wire

// ===== tb/sv/smoother_result_monitor.sv =====
// Result monitor for the weighted seven-tap smoother: predicts and checks results.
// Depends on wsts_pkg for the result width; watches both stream channels passively.
`timescale 1ns / 100ps

module smoother_result_monitor (
    input  logic                             aclk,
    input  logic                             aresetn,
    // tdata: sample [15:0].
    input  logic [15:0]                      s_axis_tdata,
    input  logic                             s_axis_tlast,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    // tdata: out_value [19:0], zero padding above.
    input  logic [wsts_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: is_smoothed [0].
    input  logic                             m_axis_tuser,
    input  logic                             m_axis_tlast,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output int                               failures,
    output int                               pending,
    output int                               results_checked,
    output int                               smoothed_seen
);

    import wsts_pkg::*;

    localparam int SMP_W = 16;
    localparam logic [2:0] FULL_WINDOW = 3'd6;
    localparam logic [2:0] LEAD_EDGE   = 3'd3;

    // One result as it should appear on the master channel.
    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             smoothed;
        logic             final_flag;
    } smoother_out_t;

    // Six most recent samples of the stream, index 5 is the newest.
    logic signed [SMP_W-1:0] recent [0:5];
    logic [2:0]              held_count;
    smoother_out_t           expected_outputs [$];
    int                      fail_count = 0;
    int                      queue_depth = 0;
    int                      compared = 0;
    int                      smoothed_count = 0;

    assign failures        = fail_count;
    assign pending         = queue_depth;
    assign results_checked = compared;
    assign smoothed_seen   = smoothed_count;

    // Raw sample scaled to Q4: a plain shift fills the 20-bit result exactly.
    function automatic logic [OUT_W-1:0] raw_q4(input logic signed [SMP_W-1:0] smp);
        return {smp, 4'b0000};
    endfunction

    // Weighted sum times 16/15, rounded toward minus infinity.
    function automatic logic [OUT_W-1:0] weighted_floor_q4(input longint signed total);
        longint signed scaled;
        longint signed quot;
        scaled = total * 16;
        quot   = scaled / 15;
        if (scaled < 0 && quot * 15 != scaled) begin
            quot = quot - 1;
        end
        return quot[OUT_W-1:0];
    endfunction

    // Work out the results one accepted sample causes, then shift it into the window.
    task automatic predict_sample(input logic signed [SMP_W-1:0] smp, input logic eos);
        smoother_out_t  batch [4];
        int             n;
        longint signed  total;
        n = 0;
        if (held_count >= FULL_WINDOW) begin
            total = longint'(recent[0]) + 2 * longint'(recent[1])
                  + 3 * longint'(recent[2]) + 3 * longint'(recent[3])
                  + 3 * longint'(recent[4]) + 2 * longint'(recent[5]) + longint'(smp);
            batch[n] = '{value: weighted_floor_q4(total), smoothed: 1'b1, final_flag: 1'b0};
            n++;
        end else if (held_count >= LEAD_EDGE) begin
            batch[n] = '{value: raw_q4(recent[3]), smoothed: 1'b0, final_flag: 1'b0};
            n++;
        end
        // The final sample flushes the unsent tail raw, then itself.
        if (eos) begin
            if (held_count >= 3'd2) begin
                batch[n] = '{value: raw_q4(recent[4]), smoothed: 1'b0, final_flag: 1'b0};
                n++;
            end
            if (held_count >= 3'd1) begin
                batch[n] = '{value: raw_q4(recent[5]), smoothed: 1'b0, final_flag: 1'b0};
                n++;
            end
            batch[n] = '{value: raw_q4(smp), smoothed: 1'b0, final_flag: 1'b0};
            n++;
        end
        if (n > 0) begin
            batch[n-1].final_flag = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            expected_outputs.insert(expected_outputs.size(), batch[i]);
        end
        for (int i = 0; i < 5; i++) begin
            recent[i] = recent[i+1];
        end
        recent[5] = smp;
        if (eos) begin
            held_count = '0;
        end else if (held_count < FULL_WINDOW) begin
            held_count = held_count + 3'd1;
        end
    endtask

    // Compare one result transfer with the oldest expectation, field by field.
    task automatic check_output();
        smoother_out_t          want;
        logic [OUT_TDATA_W-1:0] want_tdata;
        compared++;
        if (m_axis_tuser) begin
            smoothed_count++;
        end
        if (expected_outputs.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none, got tdata=%h tuser=%b tlast=%b",
                     $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            return;
        end
        want       = expected_outputs.pop_front();
        want_tdata = OUT_TDATA_W'(want.value);
        if (m_axis_tdata !== want_tdata) begin
            fail_count++;
            $display("%0t: out_value mismatch, expected %h, got %h",
                     $time, want_tdata, m_axis_tdata);
        end
        if (m_axis_tuser !== want.smoothed) begin
            fail_count++;
            $display("%0t: is_smoothed mismatch, expected %b, got %b",
                     $time, want.smoothed, m_axis_tuser);
        end
        if (m_axis_tlast !== want.final_flag) begin
            fail_count++;
            $display("%0t: last_result mismatch, expected %b, got %b",
                     $time, want.final_flag, m_axis_tlast);
        end
    endtask

    // Results are checked before the same edge's sample is predicted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            held_count = '0;
            for (int i = 0; i < 6; i++) begin
                recent[i] = '0;
            end
            expected_outputs.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_output();
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_sample(s_axis_tdata, s_axis_tlast);
            end
        end
        queue_depth = expected_outputs.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the smoother testbench: clock, reset, sample streams and the verdict.
// Depends on wsts_pkg, the smoother unit and smoother_result_monitor.
`timescale 1ns / 100ps

module testbench;
    import wsts_pkg::*;

    localparam int PRESSURE_CYCLES = 150;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic [15:0]            s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;

    int   tx_idle_pct  = 0;
    int   rx_idle_pct  = 0;
    int   phase        = 0;
    logic rx_hold      = 1'b0;
    int   samples_sent = 0;
    int   streams_sent = 0;

    int failures;
    int pending;
    int results_checked;
    int smoothed_seen;

    weighted_seven_tap_smoother_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    smoother_result_monitor u_result_monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .failures        (failures),
        .pending         (pending),
        .results_checked (results_checked),
        .smoothed_seen   (smoothed_seen)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Reset is held low at the start, then released.
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Receiver: random back-pressure, or a solid stall while a hold is in force.
    initial begin
        forever begin
            @(posedge aclk);
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver stall in the last phase so the pipeline fills and stalls its input.
    initial begin
        wait (phase == 3);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Safety net against a hung handshake.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Offer one sample, with random idle cycles ahead of it, and wait for the transfer.
    task automatic send_sample(input logic [15:0] smp, input logic eos);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= eos;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        samples_sent++;
        if (eos) begin
            streams_sent++;
        end
    endtask

    // Mostly full-range random values, with the extremes and sign boundary mixed in.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return {16{1'($urandom_range(1))}};
            default: return 16'($urandom);
        endcase
    endfunction

    // Whole streams of random length until about the given number of samples went out.
    task automatic run_streams(input int target);
        int start;
        int len;
        int r;
        start = samples_sent;
        while (samples_sent - start < target) begin
            r = $urandom_range(99);
            if (r < 20) begin
                len = $urandom_range(6, 1);
            end else if (r < 90) begin
                len = $urandom_range(24, 7);
            end else begin
                len = $urandom_range(60, 25);
            end
            for (int i = 0; i < len; i++) begin
                send_sample(pick_sample(), i == len - 1);
            end
        end
    endtask

    initial begin
        wait (aresetn);
        @(posedge aclk);

        // Sender idles a little, receiver a lot.
        phase       = 1;
        tx_idle_pct = 10;
        rx_idle_pct = 73;

        // Short streams of one, two and three samples come out raw only.
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        // Seven full-scale samples: the final one flushes the full set of four results.
        for (int i = 0; i < 7; i++) begin
            send_sample(16'h7FFF, i == 6);
        end
        // Most negative samples with one -1 so the sums need flooring.
        for (int i = 0; i < 8; i++) begin
            send_sample(i == 3 ? 16'hFFFF : 16'h8000, i == 7);
        end
        // Alternating bit patterns in a four-sample stream.
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h0F0F, 1'b0);
        send_sample(16'hF0F0, 1'b1);

        run_streams(140);

        // Sender idles a lot, receiver a little.
        phase       = 2;
        tx_idle_pct = 73;
        rx_idle_pct = 10;
        run_streams(140);

        // No idling on either side, apart from the long receiver stall.
        phase       = 3;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_streams(145);
        s_axis_tvalid <= 1'b0;

        // Let the monitor record the last transfer before draining.
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d samples in %0d streams under three idle mixes and a long stall.",
                 samples_sent, streams_sent);
        $display("Compared %0d results, %0d of them weighted averages.",
                 results_checked, smoothed_seen);
        if (failures == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
